// ===== src/tricc_pkg.sv =====
// Package for the triangle circumcenter pipeline.
// Holds default parameter values and the fixed output width; no dependencies.
`default_nettype none
package tricc_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int OUT_W          = 58;
endpackage
`default_nettype wire

// ===== src/triangle_circumcentre.sv =====
// Triangle circumcenter: fully pipelined, one request per cycle while the output is not stalled.
// Depends on tricc_pkg (default widths, output width).
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+----------------------------------------
//  input   | i_valid | o_ready | i_a_x i_a_y i_b_x i_b_y i_c_x i_c_y
//  output  | o_valid | i_ready | o_centre_x o_centre_y o_finite
//
// Throughput is one request per cycle while the output is not stalled; the restoring
// divider produces one quotient bit per stage.
// Four arithmetic stages (differences/squares, products, sums, magnitudes) precede it.
// Synchronous active-low reset clears the valid bits only.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module triangle_circumcentre #(
    parameter int COORD_BITS = tricc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tricc_pkg::FRAC_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire signed [COORD_BITS-1:0]       i_a_x,
    input  wire signed [COORD_BITS-1:0]       i_a_y,
    input  wire signed [COORD_BITS-1:0]       i_b_x,
    input  wire signed [COORD_BITS-1:0]       i_b_y,
    input  wire signed [COORD_BITS-1:0]       i_c_x,
    input  wire signed [COORD_BITS-1:0]       i_c_y,
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic signed [tricc_pkg::OUT_W-1:0] o_centre_x,
    output logic signed [tricc_pkg::OUT_W-1:0] o_centre_y,
    output logic                              o_finite
);
    import tricc_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int EW   = CW + 1;            // coordinate difference
    localparam int SQW  = 2 * CW + 1;        // signed |v|^2
    localparam int PDW  = 2 * CW + 1;        // coord * difference
    localparam int PNW  = SQW + EW;          // |v|^2 * difference
    localparam int DW   = 2 * CW + 3;        // D
    localparam int NW   = PNW + 2;           // NX, NY
    localparam int NSW  = NW + FRAC_BITS;    // scaled numerator, signed
    localparam int QW   = NSW - 1;           // numerator magnitude / quotient
    localparam int MW   = DW;                // |2D|

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // Stage 1: differences and squared norms
    logic                 r_v1;
    logic signed [CW-1:0] r_ax, r_bx, r_cx;
    logic signed [EW-1:0] r_e1, r_e2, r_e3, r_f1, r_f2, r_f3;
    logic signed [SQW-1:0] r_sa, r_sb, r_sc;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax <= i_a_x; r_bx <= i_b_x; r_cx <= i_c_x;
            r_e1 <= EW'(i_b_y) - EW'(i_c_y);
            r_e2 <= EW'(i_c_y) - EW'(i_a_y);
            r_e3 <= EW'(i_a_y) - EW'(i_b_y);
            r_f1 <= EW'(i_c_x) - EW'(i_b_x);
            r_f2 <= EW'(i_a_x) - EW'(i_c_x);
            r_f3 <= EW'(i_b_x) - EW'(i_a_x);
            r_sa <= SQW'(i_a_x) * SQW'(i_a_x) + SQW'(i_a_y) * SQW'(i_a_y);
            r_sb <= SQW'(i_b_x) * SQW'(i_b_x) + SQW'(i_b_y) * SQW'(i_b_y);
            r_sc <= SQW'(i_c_x) * SQW'(i_c_x) + SQW'(i_c_y) * SQW'(i_c_y);
        end
    end

    // Stage 2: products
    logic                  r_v2;
    logic signed [PDW-1:0] r_pd1, r_pd2, r_pd3;
    logic signed [PNW-1:0] r_px1, r_px2, r_px3, r_py1, r_py2, r_py3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pd1 <= PDW'(r_ax) * PDW'(r_e1);
            r_pd2 <= PDW'(r_bx) * PDW'(r_e2);
            r_pd3 <= PDW'(r_cx) * PDW'(r_e3);
            r_px1 <= PNW'(r_sa) * PNW'(r_e1);
            r_px2 <= PNW'(r_sb) * PNW'(r_e2);
            r_px3 <= PNW'(r_sc) * PNW'(r_e3);
            r_py1 <= PNW'(r_sa) * PNW'(r_f1);
            r_py2 <= PNW'(r_sb) * PNW'(r_f2);
            r_py3 <= PNW'(r_sc) * PNW'(r_f3);
        end
    end

    // Stage 3: sums
    logic                 r_v3;
    logic signed [DW-1:0] r_d;
    logic signed [NW-1:0] r_nx, r_ny;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d  <= DW'(r_pd1) + DW'(r_pd2) + DW'(r_pd3);
            r_nx <= NW'(r_px1) + NW'(r_px2) + NW'(r_px3);
            r_ny <= NW'(r_py1) + NW'(r_py2) + NW'(r_py3);
        end
    end

    // Stage 4: signs and magnitudes feed divider stage 0
    logic signed [NSW-1:0] w_snx, w_sny, w_anx, w_any;
    logic signed [DW:0]    w_d2, w_ad2;
    assign w_snx = NSW'(r_nx) <<< FRAC_BITS;
    assign w_sny = NSW'(r_ny) <<< FRAC_BITS;
    assign w_anx = w_snx[NSW-1] ? -w_snx : w_snx;
    assign w_any = w_sny[NSW-1] ? -w_sny : w_sny;
    assign w_d2  = (DW + 1)'(r_d) <<< 1;
    assign w_ad2 = w_d2[DW] ? -w_d2 : w_d2;

    logic          r_vd  [0:QW];
    logic [MW-1:0] r_rx  [0:QW];
    logic [MW-1:0] r_ry  [0:QW];
    logic [QW-1:0] r_qx  [0:QW];
    logic [QW-1:0] r_qy  [0:QW];
    logic [MW-1:0] r_den [0:QW];
    logic          r_ngx [0:QW];
    logic          r_ngy [0:QW];
    logic          r_fin [0:QW];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx[0]  <= '0;
            r_ry[0]  <= '0;
            r_qx[0]  <= w_anx[QW-1:0];
            r_qy[0]  <= w_any[QW-1:0];
            r_den[0] <= w_ad2[MW-1:0];
            r_ngx[0] <= w_snx[NSW-1] ^ r_d[DW-1];
            r_ngy[0] <= w_sny[NSW-1] ^ r_d[DW-1];
            r_fin[0] <= (r_d != '0);
        end
    end

    // Divider stages: one restoring step per stage for both quotients
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [MW:0] w_tx, w_ty, w_sx, w_sy, w_dn;
        logic        w_gx, w_gy;
        assign w_dn = {1'b0, r_den[k]};
        assign w_tx = {r_rx[k], r_qx[k][QW-1]};
        assign w_ty = {r_ry[k], r_qy[k][QW-1]};
        assign w_sx = w_tx - w_dn;
        assign w_sy = w_ty - w_dn;
        assign w_gx = (w_tx >= w_dn);
        assign w_gy = (w_ty >= w_dn);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rx[k+1]  <= w_gx ? w_sx[MW-1:0] : w_tx[MW-1:0];
                r_ry[k+1]  <= w_gy ? w_sy[MW-1:0] : w_ty[MW-1:0];
                r_qx[k+1]  <= {r_qx[k][QW-2:0], w_gx};
                r_qy[k+1]  <= {r_qy[k][QW-2:0], w_gy};
                r_den[k+1] <= r_den[k];
                r_ngx[k+1] <= r_ngx[k];
                r_ngy[k+1] <= r_ngy[k];
                r_fin[k+1] <= r_fin[k];
            end
        end
    end

    // Output stage: restore sign, zero degenerate triangles
    logic signed [QW:0] w_qx, w_qy, w_ox, w_oy;
    assign w_qx = {1'b0, r_qx[QW]};
    assign w_qy = {1'b0, r_qy[QW]};
    assign w_ox = !r_fin[QW] ? '0 : (r_ngx[QW] ? -w_qx : w_qx);
    assign w_oy = !r_fin[QW] ? '0 : (r_ngy[QW] ? -w_qy : w_qy);

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_centre_x <= OUT_W'(w_ox);
            o_centre_y <= OUT_W'(w_oy);
            o_finite   <= r_fin[QW];
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
            for (int j = 0; j <= QW; j++) r_vd[j] <= 1'b0;
        end else if (en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_vd[0] <= r_v3;
            for (int j = 0; j < QW; j++) r_vd[j+1] <= r_vd[j];
            o_valid <= r_vd[QW];
        end
    end

`ifndef SYNTHESIS
    // degenerate results carry zero centers
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_finite) |-> (o_centre_x == '0 && o_centre_y == '0))
        else $error("degenerate result not zero");
    // final remainder is below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vd[QW] && r_fin[QW]) |-> (r_rx[QW] < r_den[QW] && r_ry[QW] < r_den[QW]))
        else $error("divider remainder out of range");
    // a stalled result holds and the pipeline stays frozen
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_vd[QW]) && $stable(r_qx[QW])))
        else $error("pipeline moved under stall");
`endif
endmodule
`default_nettype wire

// ===== tb/tricc_checker.sv =====
// Checker for the triangle circumcenter pipeline: watches both channels,
// predicts each result from the accepted request and compares. Depends on tricc_pkg.
`timescale 1ns / 100ps
`default_nettype none
module tricc_checker #(
    parameter int COORD_BITS = tricc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tricc_pkg::FRAC_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    input  wire                                i_ready_in,
    input  wire signed [COORD_BITS-1:0]        i_a_x,
    input  wire signed [COORD_BITS-1:0]        i_a_y,
    input  wire signed [COORD_BITS-1:0]        i_b_x,
    input  wire signed [COORD_BITS-1:0]        i_b_y,
    input  wire signed [COORD_BITS-1:0]        i_c_x,
    input  wire signed [COORD_BITS-1:0]        i_c_y,
    input  wire                                i_out_valid,
    input  wire                                i_out_ready,
    input  wire signed [tricc_pkg::OUT_W-1:0]  i_centre_x,
    input  wire signed [tricc_pkg::OUT_W-1:0]  i_centre_y,
    input  wire                                i_finite,
    output int                                 o_errors,
    output int                                 o_pending
);
    import tricc_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0] cx;
        logic signed [OUT_W-1:0] cy;
        logic                    fin;
    } t_centre;

    t_centre centre_q[$];

    // exact integer circumcenter; 64-bit products cannot overflow at these widths
    function automatic t_centre circumcenter(longint ax, longint ay, longint bx,
                                             longint by, longint cx, longint cy);
        longint  d, sa, sb, sc, nx, ny, den;
        t_centre r;
        r = '0;
        d = ax * (by - cy) + bx * (cy - ay) + cx * (ay - by);
        if (d == 0) return r;   // degenerate: collinear or coincident
        sa = ax * ax + ay * ay;
        sb = bx * bx + by * by;
        sc = cx * cx + cy * cy;
        nx = sa * (by - cy) + sb * (cy - ay) + sc * (ay - by);
        ny = sa * (cx - bx) + sb * (ax - cx) + sc * (bx - ax);
        den = 2 * d;
        r.cx = OUT_W'((nx * (longint'(1) << FRAC_BITS)) / den);
        r.cy = OUT_W'((ny * (longint'(1) << FRAC_BITS)) / den);
        r.fin = 1'b1;
        return r;
    endfunction

    assign o_pending = centre_q.size();

    initial o_errors = 0;

    // record requests and compare results
    always @(posedge i_clk) begin
        t_centre exp_c;
        if (i_rst_n) begin
            if (i_valid && i_ready_in)
                centre_q.push_back(circumcenter(i_a_x, i_a_y, i_b_x, i_b_y, i_c_x, i_c_y));
            if (i_out_valid && i_out_ready) begin
                if (centre_q.size() == 0) begin
                    $display("%0t: result with no request pending: x=%0d y=%0d f=%0b",
                             $time, i_centre_x, i_centre_y, i_finite);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_c = centre_q.pop_front();
                    if (exp_c.cx !== i_centre_x || exp_c.cy !== i_centre_y ||
                        exp_c.fin !== i_finite) begin
                        $display("%0t: mismatch expected x=%0d y=%0d f=%0b, got x=%0d y=%0d f=%0b",
                                 $time, exp_c.cx, exp_c.cy, exp_c.fin,
                                 i_centre_x, i_centre_y, i_finite);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Top of the circumcenter testbench: clock, reset, request and result traffic.
// Depends on tricc_pkg, triangle_circumcentre and tricc_checker.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int CW       = tricc_pkg::COORD_BITS_DEF;
    localparam int FB       = tricc_pkg::FRAC_BITS_DEF;
    localparam int LATENCY  = 5 + 3 * CW + 3 + FB;
    localparam int N_RANDOM = 1030;
    localparam int LIMIT    = 400000;

    logic i_clk, i_rst_n, i_valid, i_ready;
    logic signed [CW-1:0] i_a_x, i_a_y, i_b_x, i_b_y, i_c_x, i_c_y;
    wire o_ready, o_valid, o_finite;
    wire signed [tricc_pkg::OUT_W-1:0] o_centre_x, o_centre_y;
    int errors, pending, n_sent, cycles;

    triangle_circumcentre i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_a_x, .i_a_y, .i_b_x, .i_b_y, .i_c_x, .i_c_y,
        .o_valid, .i_ready, .o_centre_x, .o_centre_y, .o_finite
    );

    tricc_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready),
        .i_a_x, .i_a_y, .i_b_x, .i_b_y, .i_c_x, .i_c_y,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_centre_x(o_centre_x), .i_centre_y(o_centre_y), .i_finite(o_finite),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // mostly short gaps, a few long
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL triangle_circumcentre");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off while requests keep coming
    initial begin
        bit held;
        int g;
        held = 0;
        i_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held && n_sent >= 300) begin
                held = 1;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            g = gap_len();
            if (g > 0) begin
                i_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // one request; valid stays up when the next follows back to back
    task automatic send_tri(int ax, ay, bx, by, cx, cy);
        int g;
        i_valid <= 1'b1;
        i_a_x <= CW'(ax); i_a_y <= CW'(ay); i_b_x <= CW'(bx);
        i_b_y <= CW'(by); i_c_x <= CW'(cx); i_c_y <= CW'(cy);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_sent++;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic logic [CW-1:0] rnd_coord(int mode);
        case (mode)
            0: return CW'($urandom());
            1: return CW'($urandom_range(0, 40) - 20);
            2: return $urandom_range(0, 1) ? CW'(16'h7fff - $urandom_range(0, 3))
                                           : CW'(16'h8000 + $urandom_range(0, 3));
            default: return CW'($urandom_range(0, 2000) - 1000);
        endcase
    endfunction

    initial begin
        logic signed [CW-1:0] ax, ay, bx, by;
        int k, m;
        cycles = 0;
        n_sent = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        {i_a_x, i_a_y, i_b_x, i_b_y, i_c_x, i_c_y} = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes and degenerate triangles
        send_tri(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_tri(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_tri(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
        send_tri(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
        send_tri(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h7fff);
        send_tri(0, 0, 1, 0, 0, 1);
        send_tri(0, 0, 0, 1, 1, 0);
        send_tri(-1, -1, 1, -1, 0, 1);
        send_tri(16'hffff, 0, 1, 0, 0, 16'hffff);
        send_tri(0, 0, 0, 0, 0, 0);                               // coincident
        send_tri(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_tri(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_tri(1, 2, 1, 2, 5, 7);                               // two coincide
        send_tri(0, 0, 3, 3, 16'h7ffe, 16'h7ffe);                 // collinear
        send_tri(16'h8000, 16'h8000, 0, 0, 16'h7fff, 16'h7fff);   // collinear
        send_tri(16'h8000, 0, 0, 0, 16'h7fff, 0);                 // horizontal line
        send_tri(5, 16'h8000, 5, 3, 5, 16'h7fff);                 // vertical line
        send_tri(1, 0, 2, 0, 1, 1);
        send_tri(3, 7, 16'hfffd, 7, 0, 16'hfff9);

        // sender pause: let the pipeline drain completely
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            m = $urandom_range(3);
            if ($urandom_range(99) < 12) begin
                // degenerate: c on line through a and b (or coincident)
                ax = rnd_coord(3); ay = rnd_coord(3);
                bx = ax + rnd_coord(1); by = ay + rnd_coord(1);
                k = $urandom_range(0, 6) - 3;
                send_tri(ax, ay, bx, by, ax + k * (bx - ax), ay + k * (by - ay));
            end else begin
                send_tri(rnd_coord(m), rnd_coord(m), rnd_coord(m),
                         rnd_coord(m), rnd_coord(m), rnd_coord(m));
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("PASS triangle_circumcentre");
        else
            $display("FAIL triangle_circumcentre");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
src/tricc_pkg.sv
src/triangle_circumcentre.sv
tb/tricc_checker.sv
tb/tb.sv
